[src/mips_basic_block_boundary_scanner_assert.svh]
// ----------------------------------------------------------------------------
// basic block scanner assertion macros
// concurrent checks clocked on clk, switched off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MIPS_BASIC_BLOCK_BOUNDARY_SCANNER_ASSERT_SVH
`define MIPS_BASIC_BLOCK_BOUNDARY_SCANNER_ASSERT_SVH

// same-cycle implication
`define MBBS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBBS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mbbs_pkg.sv]
// ----------------------------------------------------------------------------
// mbbs_pkg
// shared types, opcode codes and defaults of the basic block scanner
// ----------------------------------------------------------------------------
package mbbs_pkg;

    // defaults for top-level parameters
    localparam int MAX_BLOCK_WORDS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic [9:0] PAGE_LAST = 10'h3FF;

    // major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BGTZL   = 6'h17;

    // special function codes
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;

    // cop0 rs codes
    localparam logic [4:0] RS_MT = 5'h04;
    localparam logic [4:0] RS_CO = 5'h10;

    // cop0 operation function codes
    localparam logic [5:0] FN_TLBR  = 6'h01;
    localparam logic [5:0] FN_TLBWI = 6'h02;
    localparam logic [5:0] FN_TLBWR = 6'h06;
    localparam logic [5:0] FN_TLBP  = 6'h08;
    localparam logic [5:0] FN_ERET  = 6'h18;

    // cop0 registers whose write closes a block
    localparam logic [4:0] CP0_ENTRYHI = 5'd10;
    localparam logic [4:0] CP0_COMPARE = 5'd11;
    localparam logic [4:0] CP0_STATUS  = 5'd12;
    localparam logic [4:0] CP0_CAUSE   = 5'd13;
    localparam logic [4:0] CP0_CONFIG  = 5'd16;

    typedef struct packed {
        logic        block_start;
        logic        fetch_ok;
        logic [9:0]  page_word;
        logic [31:0] insn;
    } item_t;

    typedef struct packed {
        logic       keep;
        logic       block_done;
        logic       block_empty;
        logic       branch_ended;
        logic [6:0] word_count;
    } result_t;

    // classified word handed from front to back
    typedef struct packed {
        logic block_start;
        logic fetch_ok;
        logic slot_branch;  // branch or jump, pulls in a delay slot
        logic stop_after;   // closes the block once kept
    } class_t;

endpackage

[src/mbbs_queue.sv]
// ----------------------------------------------------------------------------
// mbbs_queue
// small register queue of classified words between front and back
// ----------------------------------------------------------------------------
module mbbs_queue #(
    parameter int DEPTH = mbbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  mbbs_pkg::class_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output mbbs_pkg::class_t rd_data,
    output logic            empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    mbbs_pkg::class_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          do_wr, do_rd;

    assign full    = (fill_reg == FW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/mbbs_front.sv]
// ----------------------------------------------------------------------------
// mbbs_front
// instruction classifier: branch with delay slot, block-closing word
// ----------------------------------------------------------------------------
module mbbs_front (
    input  mbbs_pkg::item_t  item,
    output mbbs_pkg::class_t cls
);

    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic       slot;
    logic       stop;

    assign op = item.insn[31:26];
    assign rs = item.insn[25:21];
    assign rt = item.insn[20:16];
    assign rd = item.insn[15:11];
    assign fn = item.insn[5:0];

    always_comb
    begin
        slot = 1'b0;
        stop = 1'b0;
        unique case (op) inside
            mbbs_pkg::OP_SPECIAL:
            begin
                slot = (fn == mbbs_pkg::FN_JR) || (fn == mbbs_pkg::FN_JALR);
                stop = (fn == mbbs_pkg::FN_SYSCALL) || (fn == mbbs_pkg::FN_BREAK);
            end
            mbbs_pkg::OP_REGIMM:
            begin
                // bltz/bgez family and their likely and link forms
                slot = (rt[3:2] == 2'b00);
            end
            [mbbs_pkg::OP_J:mbbs_pkg::OP_BGTZ],
            [mbbs_pkg::OP_BEQL:mbbs_pkg::OP_BGTZL]:
            begin
                slot = 1'b1;
            end
            mbbs_pkg::OP_COP0:
            begin
                if (rs == mbbs_pkg::RS_CO)
                begin
                    stop = (fn == mbbs_pkg::FN_TLBR)  || (fn == mbbs_pkg::FN_TLBWI) ||
                           (fn == mbbs_pkg::FN_TLBWR) || (fn == mbbs_pkg::FN_TLBP)  ||
                           (fn == mbbs_pkg::FN_ERET);
                end
                else if (rs == mbbs_pkg::RS_MT)
                begin
                    stop = (rd == mbbs_pkg::CP0_ENTRYHI) || (rd == mbbs_pkg::CP0_COMPARE) ||
                           (rd == mbbs_pkg::CP0_STATUS)  || (rd == mbbs_pkg::CP0_CAUSE)   ||
                           (rd == mbbs_pkg::CP0_CONFIG);
                end
            end
            default:
            begin
                slot = 1'b0;
            end
        endcase
    end

    assign cls.block_start = item.block_start;
    assign cls.fetch_ok    = item.fetch_ok;
    assign cls.slot_branch = slot;
    assign cls.stop_after  = stop || (item.page_word == mbbs_pkg::PAGE_LAST);

endmodule

[src/mbbs_back.sv]
// ----------------------------------------------------------------------------
// mbbs_back
// block state tracker and result register
// ----------------------------------------------------------------------------
module mbbs_back #(
    parameter int MAX_BLOCK_WORDS = mbbs_pkg::MAX_BLOCK_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mbbs_pkg::class_t cls,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output mbbs_pkg::result_t result
);

    // block can reach one word past the limit through a delay slot
    localparam int CW = $clog2(MAX_BLOCK_WORDS + 2);

    logic [CW-1:0]     count_reg, count_next;
    logic              await_reg, await_next;
    logic              open_reg, open_next;
    logic              branch_reg, branch_next;
    logic              valid_reg, valid_next;
    mbbs_pkg::result_t result_reg, result_next;

    logic [CW-1:0] count_base;
    logic [CW-1:0] count_new;
    logic          await_base;
    logic          branch_base;
    logic          done;

    assign q_pop  = !q_empty && (!valid_reg || pop);
    assign empty  = !valid_reg;
    assign result = result_reg;

    always_comb
    begin
        count_base  = cls.block_start ? '0 : count_reg;
        await_base  = cls.block_start ? 1'b0 : await_reg;
        branch_base = cls.block_start ? 1'b0 : branch_reg;

        count_next  = count_reg;
        await_next  = await_reg;
        open_next   = open_reg;
        branch_next = branch_reg;
        valid_next  = valid_reg;
        result_next = result_reg;
        count_new   = count_base;
        done        = 1'b0;

        if (valid_reg && pop)
        begin
            valid_next = 1'b0;
        end

        if (q_pop)
        begin
            valid_next  = 1'b1;
            result_next = '0;
            if (cls.block_start || open_reg)
            begin
                await_next  = await_base;
                branch_next = branch_base;
                if (await_base)
                begin
                    // delay slot: kept if fetched, block closes either way
                    result_next.keep         = cls.fetch_ok;
                    count_new                = count_base + CW'(cls.fetch_ok);
                    done                     = 1'b1;
                    result_next.branch_ended = branch_base;
                end
                else if (!cls.fetch_ok)
                begin
                    done = 1'b1;
                end
                else
                begin
                    result_next.keep = 1'b1;
                    count_new        = count_base + CW'(1);
                    if (cls.slot_branch)
                    begin
                        await_next  = 1'b1;
                        branch_next = 1'b1;
                    end
                    else if (cls.stop_after || (count_new >= CW'(MAX_BLOCK_WORDS)))
                    begin
                        done = 1'b1;
                    end
                end

                result_next.block_done  = done;
                result_next.block_empty = done && (count_new == '0);
                result_next.word_count  = 7'(count_new);

                if (done)
                begin
                    count_next  = '0;
                    await_next  = 1'b0;
                    open_next   = 1'b0;
                    branch_next = 1'b0;
                end
                else
                begin
                    count_next = count_new;
                    open_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            await_reg  <= 1'b0;
            open_reg   <= 1'b0;
            branch_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            await_reg  <= await_next;
            open_reg   <= open_next;
            branch_reg <= branch_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

[src/mips_basic_block_boundary_scanner.sv]
// ----------------------------------------------------------------------------
// mips_basic_block_boundary_scanner
// finds where a mips basic block ends, one fetched instruction word at a time
// ----------------------------------------------------------------------------
// usage
//   input side is a queue write port: drive item and raise push; the word is
//   taken at a clock edge where push is high and full is low
//   result side is a queue read port: while empty is low the oldest result
//   word sits on result; it is taken at an edge where pop is high
//   every input word gives exactly one result word, in order
// timing
//   one word per cycle sustained while results are popped; a word taken is
//   first held in the decoupling queue, then the block state update loads
//   its result into the result register, from where it can be popped
// stall
//   while pop is low the result register holds, the queue fills and full
//   rises after QUEUE_DEPTH further words; nothing is dropped
// reset
//   rst_n low clears the queue and the block state and marks the result
//   register empty; no block is open afterwards, so words without
//   block_start yield all-zero results until a block is started
// ----------------------------------------------------------------------------
module mips_basic_block_boundary_scanner #(
    parameter int MAX_BLOCK_WORDS = mbbs_pkg::MAX_BLOCK_WORDS_DEF,
    parameter int QUEUE_DEPTH     = mbbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mbbs_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output mbbs_pkg::result_t result
);

    // classified word from the decoder
    mbbs_pkg::class_t cls_in;
    // head of the queue seen by the block tracker
    mbbs_pkg::class_t cls_head;
    logic             q_empty;
    logic             q_pop;

    // front: decode opcode into branch / closing classes
    mbbs_front u_front (
        .item (item),
        .cls  (cls_in)
    );

    // queue lets decode keep taking words while results back up
    mbbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (cls_head),
        .empty   (q_empty)
    );

    // back: block length, delay slot tracking, result register
    mbbs_back #(
        .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cls     (cls_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

`include "mips_basic_block_boundary_scanner_assert.svh"

    // an open block never reports empty or branch end
    `MBBS_ASSERT_IMP(a_open_flags, !empty && !result.block_done,
        !result.block_empty && !result.branch_ended, "flags set on open block")

    // an empty closed block keeps no word and reports zero length
    `MBBS_ASSERT_IMP(a_empty_len, !empty && result.block_empty,
        !result.keep && (result.word_count == 7'd0), "empty block with words")

    // a word taken from the queue always lands in the result register
    `MBBS_ASSERT_NXT(a_pop_lands, q_pop, !empty, "queued word lost")

endmodule

[dv/mips_basic_block_boundary_scanner_tb.sv]
// ----------------------------------------------------------------------------
// mips_basic_block_boundary_scanner_tb
// self-checking bench: a directed run through block endings but the word limit,
// then random blocks with random content, noise words and abandoned blocks;
// every result word is checked against a bench-side scanner model
// ----------------------------------------------------------------------------
module mips_basic_block_boundary_scanner_tb;

    localparam int BLOCK_LIMIT    = mbbs_pkg::MAX_BLOCK_WORDS_DEF;
    localparam int RANDOM_WORDS   = 1850;
    localparam int IDLE_LIMIT     = 2000;  // cycles without any handshake
    localparam int DRAIN_CYCLES   = 10;    // margin after the last checked result

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    mbbs_pkg::item_t   item = '0;
    logic              empty;
    logic              pop = 1'b0;
    mbbs_pkg::result_t result;

    mips_basic_block_boundary_scanner uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scanner model state, mirrors the block's own bookkeeping
    // ------------------------------------------------------------------
    int      blk_len = 0;           // words kept in the open block
    bit      slot_pending = 1'b0;   // next word is a delay slot
    bit      blk_open = 1'b0;
    bit      blk_has_branch = 1'b0;

    mbbs_pkg::item_t   send_queue[$];         // words waiting for the driver
    mbbs_pkg::result_t expected_results[$];   // predictions not yet seen
    int      fail_count = 0;
    int      idle_cycles = 0;

    function automatic void queue_word(mbbs_pkg::item_t w);
        send_queue = {send_queue, w};
    endfunction

    // branch or jump: pulls in a delay slot
    function automatic bit is_branch_word(logic [31:0] w);
        logic [5:0] op;
        op = w[31:26];
        if (op == mbbs_pkg::OP_SPECIAL)
            return w[5:0] == mbbs_pkg::FN_JR || w[5:0] == mbbs_pkg::FN_JALR;
        if (op == mbbs_pkg::OP_REGIMM)
            return w[19:18] == 2'b00;  // bltz/bgez family incl. link and likely
        return (op >= mbbs_pkg::OP_J && op <= mbbs_pkg::OP_BGTZ) ||
               (op >= mbbs_pkg::OP_BEQL && op <= mbbs_pkg::OP_BGTZL);
    endfunction

    // words after which the block closes straight away
    function automatic bit is_serialising_word(logic [31:0] w);
        logic [5:0] op;
        logic [5:0] fn;
        logic [4:0] rs;
        logic [4:0] rd;
        op = w[31:26];
        fn = w[5:0];
        rs = w[25:21];
        rd = w[15:11];
        if (op == mbbs_pkg::OP_SPECIAL)
            return fn == mbbs_pkg::FN_SYSCALL || fn == mbbs_pkg::FN_BREAK;
        if (op == mbbs_pkg::OP_COP0 && rs == mbbs_pkg::RS_CO)
            return fn == mbbs_pkg::FN_TLBR || fn == mbbs_pkg::FN_TLBWI ||
                   fn == mbbs_pkg::FN_TLBWR || fn == mbbs_pkg::FN_TLBP ||
                   fn == mbbs_pkg::FN_ERET;
        if (op == mbbs_pkg::OP_COP0 && rs == mbbs_pkg::RS_MT)
            return rd == mbbs_pkg::CP0_ENTRYHI || rd == mbbs_pkg::CP0_COMPARE ||
                   rd == mbbs_pkg::CP0_STATUS || rd == mbbs_pkg::CP0_CAUSE ||
                   rd == mbbs_pkg::CP0_CONFIG;
        return 1'b0;
    endfunction

    function automatic void clear_block();
        blk_len        = 0;
        slot_pending   = 1'b0;
        blk_open       = 1'b0;
        blk_has_branch = 1'b0;
    endfunction

    // advance the model by one accepted word and give the result it causes
    function automatic mbbs_pkg::result_t scan_word(mbbs_pkg::item_t w);
        mbbs_pkg::result_t r;
        r = '0;
        if (w.block_start)
            clear_block();
        // idle word: nothing open and no new block asked for
        if (!w.block_start && !blk_open)
            return r;
        blk_open = 1'b1;
        if (slot_pending)
        begin
            // delay slot: kind and page position not looked at
            if (w.fetch_ok)
            begin
                r.keep = 1'b1;
                blk_len++;
            end
            r.block_done   = 1'b1;
            r.branch_ended = blk_has_branch;
        end
        else if (!w.fetch_ok)
        begin
            r.block_done = 1'b1;
        end
        else
        begin
            r.keep = 1'b1;
            blk_len++;
            if (is_branch_word(w.insn))
            begin
                slot_pending   = 1'b1;
                blk_has_branch = 1'b1;
            end
            else if (is_serialising_word(w.insn) || w.page_word == mbbs_pkg::PAGE_LAST ||
                     blk_len >= BLOCK_LIMIT)
            begin
                r.block_done = 1'b1;
            end
        end
        r.word_count = blk_len[6:0];
        if (r.block_done)
        begin
            r.block_empty = (blk_len == 0);
            clear_block();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    function automatic mbbs_pkg::item_t mk_word(bit first, bit ok, int pw,
                                                logic [31:0] insn);
        mbbs_pkg::item_t w;
        w.block_start = first;
        w.fetch_ok    = ok;
        w.page_word   = pw[9:0];
        w.insn        = insn;
        return w;
    endfunction

    function automatic mbbs_pkg::item_t noise_word();
        mbbs_pkg::item_t w;
        w.block_start = $urandom_range(0, 3) == 0;
        w.fetch_ok    = 1'($urandom_range(0, 1));
        w.page_word   = 10'($urandom_range(0, 1023));
        w.insn        = $urandom;
        return w;
    endfunction

    function automatic logic [31:0] branch_insn();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 4))
            0: w = {mbbs_pkg::OP_SPECIAL, w[25:6],
                    ($urandom_range(0, 1) ? mbbs_pkg::FN_JR : mbbs_pkg::FN_JALR)};
            1: w = {mbbs_pkg::OP_REGIMM, w[25:21], w[20], 2'b00, w[17:0]};
            2: w[31:26] = 6'($urandom_range(mbbs_pkg::OP_J, mbbs_pkg::OP_BGTZ));
            default: w[31:26] = 6'($urandom_range(mbbs_pkg::OP_BEQL, mbbs_pkg::OP_BGTZL));
        endcase
        return w;
    endfunction

    function automatic logic [31:0] serialising_insn();
        logic [31:0] w;
        logic [5:0]  co_fn[5];
        logic [4:0]  mt_rd[5];
        co_fn = '{mbbs_pkg::FN_TLBR, mbbs_pkg::FN_TLBWI, mbbs_pkg::FN_TLBWR,
                  mbbs_pkg::FN_TLBP, mbbs_pkg::FN_ERET};
        mt_rd = '{mbbs_pkg::CP0_ENTRYHI, mbbs_pkg::CP0_COMPARE, mbbs_pkg::CP0_STATUS,
                  mbbs_pkg::CP0_CAUSE, mbbs_pkg::CP0_CONFIG};
        w = $urandom;
        case ($urandom_range(0, 2))
            0: w = {mbbs_pkg::OP_SPECIAL, w[25:6],
                    ($urandom_range(0, 1) ? mbbs_pkg::FN_SYSCALL : mbbs_pkg::FN_BREAK)};
            1: w = {mbbs_pkg::OP_COP0, mbbs_pkg::RS_CO, w[20:6],
                    co_fn[$urandom_range(0, 4)]};
            default: w = {mbbs_pkg::OP_COP0, mbbs_pkg::RS_MT, w[20:16],
                          mt_rd[$urandom_range(0, 4)], w[10:0]};
        endcase
        return w;
    endfunction

    // ordinary word, often a near miss of one of the closing encodings
    function automatic logic [31:0] plain_insn();
        logic [31:0] w;
        do
        begin
            w = $urandom;
            case ($urandom_range(0, 3))
                1: w[31:26] = mbbs_pkg::OP_SPECIAL;
                2: w[31:26] = mbbs_pkg::OP_REGIMM;
                3: w[31:21] = {mbbs_pkg::OP_COP0,
                               ($urandom_range(0, 1) ? mbbs_pkg::RS_CO : mbbs_pkg::RS_MT)};
                default: ;
            endcase
        end
        while (is_branch_word(w) || is_serialising_word(w));
        return w;
    endfunction

    // delay slot word: anything, sometimes a failed fetch
    function automatic mbbs_pkg::item_t slot_word();
        return mk_word(1'b0, $urandom_range(0, 7) != 0, $urandom_range(0, 1023), $urandom);
    endfunction

    // one random block, returns the number of words it queued
    function automatic int queue_block();
        mbbs_pkg::item_t blk[$];
        int    kind;
        int    len;
        int    start;
        int    i;
        int    n;
        kind = $urandom_range(0, 99);
        if (kind < 6)
            len = BLOCK_LIMIT - 1;
        else if ($urandom_range(0, 9) < 8)
            len = $urandom_range(0, 6);
        else
            len = $urandom_range(7, 40);
        if (kind >= 6 && kind < 12)
            start = int'(mbbs_pkg::PAGE_LAST) - len;
        else
            start = $urandom_range(0, int'(mbbs_pkg::PAGE_LAST) - 1 - len);
        for (i = 0; i < len; i++)
            blk = {blk, mk_word(1'b0, 1'b1, start + i, plain_insn())};
        if (kind < 12)
        begin
            // word limit or page end, reached by a plain word or by a branch
            if ($urandom_range(0, 1))
                blk = {blk, mk_word(1'b0, 1'b1, start + len, plain_insn())};
            else
            begin
                blk = {blk, mk_word(1'b0, 1'b1, start + len, branch_insn())};
                blk = {blk, slot_word()};
            end
        end
        else if (kind < 46)
        begin
            blk = {blk, mk_word(1'b0, 1'b1, start + len, branch_insn())};
            blk = {blk, slot_word()};
        end
        else if (kind < 66)
            blk = {blk, mk_word(1'b0, 1'b1, start + len, serialising_insn())};
        else if (kind < 76)
            blk = {blk, mk_word(1'b0, 1'b0, start + len, $urandom)};
        else if (kind < 86)
        begin
            // abandoned block, the next block start restarts; maybe mid-branch
            if ($urandom_range(0, 1))
                blk = {blk, mk_word(1'b0, 1'b1, start + len, branch_insn())};
        end
        else
        begin
            // noise, content not shaped at all
            n = $urandom_range(1, 4);
            repeat (n)
                queue_word(noise_word());
            return n;
        end
        if (blk.size() == 0)
            blk = {blk, mk_word(1'b0, 1'b1, start, plain_insn())};
        blk[0].block_start = 1'b1;
        for (i = 0; i < blk.size(); i++)
            queue_word(blk[i]);
        return blk.size();
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued words, predicts on every accepted one
    // ------------------------------------------------------------------
    int              send_gap = 0;
    bit              tx_calm = 1'b0;
    logic            nxt_push;
    mbbs_pkg::item_t nxt_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            item     <= '0;
            send_gap <= 0;
        end
        else
        begin
            nxt_push = push;
            nxt_item = item;
            if (push && !full)
            begin
                expected_results = {expected_results, scan_word(item)};
                nxt_push = 1'b0;
            end
            if ($urandom_range(0, 199) == 0)
                tx_calm <= !tx_calm;
            // a word held against full stays; otherwise wait out the gap
            if (!nxt_push)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (send_queue.size() > 0)
                begin
                    nxt_item = send_queue.pop_front();
                    nxt_push = 1'b1;
                    send_gap <= pick_gap(tx_calm);
                end
            end
            push <= nxt_push;
            item <= nxt_item;
        end
    end

    // ------------------------------------------------------------------
    // monitor: takes result words with random back-pressure and checks them
    // ------------------------------------------------------------------
    int                pop_stall = 0;
    bit                rx_calm = 1'b0;
    mbbs_pkg::result_t want;

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            pop_stall <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("keep", want.keep, result.keep);
                    check_field("block_done", want.block_done, result.block_done);
                    check_field("block_empty", want.block_empty, result.block_empty);
                    check_field("branch_ended", want.branch_ended, result.branch_ended);
                    check_field("word_count", want.word_count, result.word_count);
                end
            end
            if ($urandom_range(0, 199) == 0)
                rx_calm <= !rx_calm;
            if (pop_stall > 0)
            begin
                pop_stall <= pop_stall - 1;
                pop       <= 1'b0;
            end
            else
            begin
                pop       <= 1'b1;
                pop_stall <= pick_gap(rx_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any handshake restarts the count
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** mips_basic_block_boundary_scanner: FAILED **");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int queued;
        queued = 0;

        // idle word straight after reset, all-zero result
        queue_word(mk_word(1'b0, 1'b1, 0, 32'hFFFF_FFFF));
        // failed fetch as first word: empty block
        queue_word(mk_word(1'b1, 1'b0, 1023, 32'h0000_0000));
        // syscall and break
        queue_word(mk_word(1'b1, 1'b1, 0,
                           {mbbs_pkg::OP_SPECIAL, 20'h0, mbbs_pkg::FN_SYSCALL}));
        queue_word(mk_word(1'b1, 1'b1, 1,
                           {mbbs_pkg::OP_SPECIAL, 20'hFFFFF, mbbs_pkg::FN_BREAK}));
        // tlb operations and eret
        queue_word(mk_word(1'b1, 1'b1, 2,
                           {mbbs_pkg::OP_COP0, mbbs_pkg::RS_CO, 15'h0, mbbs_pkg::FN_TLBR}));
        queue_word(mk_word(1'b1, 1'b1, 3,
                           {mbbs_pkg::OP_COP0, mbbs_pkg::RS_CO, 15'h0, mbbs_pkg::FN_TLBWI}));
        queue_word(mk_word(1'b1, 1'b1, 4,
                           {mbbs_pkg::OP_COP0, mbbs_pkg::RS_CO, 15'h0, mbbs_pkg::FN_TLBWR}));
        queue_word(mk_word(1'b1, 1'b1, 5,
                           {mbbs_pkg::OP_COP0, mbbs_pkg::RS_CO, 15'h0, mbbs_pkg::FN_TLBP}));
        queue_word(mk_word(1'b1, 1'b1, 6,
                           {mbbs_pkg::OP_COP0, mbbs_pkg::RS_CO, 15'h0, mbbs_pkg::FN_ERET}));
        // mtc0 to each register that closes a block
        queue_word(mk_word(1'b1, 1'b1, 7, {mbbs_pkg::OP_COP0, mbbs_pkg::RS_MT, 5'd3,
                                           mbbs_pkg::CP0_ENTRYHI, 11'h0}));
        queue_word(mk_word(1'b1, 1'b1, 8, {mbbs_pkg::OP_COP0, mbbs_pkg::RS_MT, 5'd3,
                                           mbbs_pkg::CP0_COMPARE, 11'h0}));
        queue_word(mk_word(1'b1, 1'b1, 9, {mbbs_pkg::OP_COP0, mbbs_pkg::RS_MT, 5'd3,
                                           mbbs_pkg::CP0_STATUS, 11'h0}));
        queue_word(mk_word(1'b1, 1'b1, 10, {mbbs_pkg::OP_COP0, mbbs_pkg::RS_MT, 5'd3,
                                            mbbs_pkg::CP0_CAUSE, 11'h0}));
        queue_word(mk_word(1'b1, 1'b1, 11, {mbbs_pkg::OP_COP0, mbbs_pkg::RS_MT, 5'd3,
                                            mbbs_pkg::CP0_CONFIG, 11'h0}));
        // open block with all-zero and all-one words, then restart mid-block
        queue_word(mk_word(1'b1, 1'b1, 20, 32'h0000_0000));
        queue_word(mk_word(1'b0, 1'b1, 21, 32'hFFFF_FFFF));
        // restarted block closes at the end of the page
        queue_word(mk_word(1'b1, 1'b1, 1023, 32'h0000_0000));
        // jump with a failed delay slot fetch
        queue_word(mk_word(1'b1, 1'b1, 30, {mbbs_pkg::OP_J, 26'h0}));
        queue_word(mk_word(1'b0, 1'b0, 1023, 32'h0000_000C));
        // jr, slot at the page end and of a closing kind: still just a slot
        queue_word(mk_word(1'b1, 1'b1, 40,
                           {mbbs_pkg::OP_SPECIAL, 20'h0, mbbs_pkg::FN_JR}));
        queue_word(mk_word(1'b0, 1'b1, 1023,
                           {mbbs_pkg::OP_SPECIAL, 20'h0, mbbs_pkg::FN_SYSCALL}));
        // regimm branch and link, then a likely branch at the last page word
        queue_word(mk_word(1'b1, 1'b1, 50, {mbbs_pkg::OP_REGIMM, 5'd1, 5'h11, 16'h0}));
        queue_word(mk_word(1'b0, 1'b1, 51, 32'h0000_0000));
        queue_word(mk_word(1'b1, 1'b1, 1023, {mbbs_pkg::OP_BGTZL, 26'h3FF_FFFF}));
        queue_word(mk_word(1'b0, 1'b1, 0, 32'h0000_0000));

        while (queued < RANDOM_WORDS)
            queued += queue_block();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // drained once nothing is queued, on the bus or still predicted
        do
            @(posedge clk);
        while (send_queue.size() != 0 || push || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("** mips_basic_block_boundary_scanner: PASSED **");
        else
            $display("** mips_basic_block_boundary_scanner: FAILED **");
        $finish;
    end

endmodule
